### hdl/bbrt_pkg.sv
// Package for the bad block remap table: sizes, widths, codes and reset values.
// Used by the interfaces, the RAM users, the core and its checker.
`timescale 1ns / 1ps

package bbrt_pkg;

  // Table sizes
  localparam int BLOCK_COUNT    = 4096;
  localparam int BAD_LIST_DEPTH = 256;

  // Field widths
  localparam int BLK_W     = 12;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 3;
  localparam int CNT_W     = $clog2(BAD_LIST_DEPTH + 1);
  localparam int REMAP_AW  = $clog2(BLOCK_COUNT);
  localparam int LIST_AW   = $clog2(BAD_LIST_DEPTH);

  // APB port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [BLK_W:0]   BLOCK_LIMIT = (BLK_W + 1)'(BLOCK_COUNT);
  localparam logic [CNT_W-1:0] LIST_FULL   = CNT_W'(BAD_LIST_DEPTH);

  // Configuration reset values
  localparam logic [BLK_W-1:0] USER_LAST_RST   = BLK_W'(3967);
  localparam logic [BLK_W-1:0] SPARE_FIRST_RST = BLK_W'(3968);
  localparam logic [BLK_W-1:0] SPARE_LAST_RST  = BLK_W'(4087);

  // Register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_USER_LAST   = 2'd0,
    REG_SPARE_FIRST = 2'd1,
    REG_SPARE_LAST  = 2'd2
  } reg_idx_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP    = 3'd0,
    ACT_MAP_SELF  = 3'd1,
    ACT_ADD_BAD   = 3'd2,
    ACT_REMAP     = 3'd3,
    ACT_BAD_SPARE = 3'd4,
    ACT_RESTART   = 3'd5
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_LISTED    = 3'd1,
    ST_RANGE     = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_FULL      = 3'd5
  } status_e;

endpackage

### hdl/bbrt_in_if.sv
// Input channel of the bad block remap table: valid/ready and one request item.
// Depends on bbrt_pkg for field widths.
`timescale 1ns / 1ps

interface bbrt_in_if;
  logic                       valid;
  logic                       ready;
  logic [bbrt_pkg::ACT_W-1:0] action;
  logic [bbrt_pkg::BLK_W-1:0] block;
  logic [bbrt_pkg::BLK_W-1:0] old_replacement;

  modport source (output valid, action, block, old_replacement, input ready);
  modport sink   (input valid, action, block, old_replacement, output ready);
endinterface

### hdl/bbrt_out_if.sv
// Output channel of the bad block remap table: valid/ready and one result item.
// Depends on bbrt_pkg for field widths.
`timescale 1ns / 1ps

interface bbrt_out_if;
  logic                        valid;
  logic                        ready;
  logic [bbrt_pkg::BLK_W-1:0]  mapped_block;
  logic [bbrt_pkg::STAT_W-1:0] status;
  logic [bbrt_pkg::BLK_W-1:0]  next_spare;
  logic [bbrt_pkg::CNT_W-1:0]  bad_count;

  modport source (output valid, mapped_block, status, next_spare, bad_count, input ready);
  modport sink   (input valid, mapped_block, status, next_spare, bad_count, output ready);
endinterface

### hdl/bbrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module bbrt_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bad_block_remap_table_core.sv
// Bad block remap table core: sequencer, remap and bad-list memories, APB registers.
// Depends on bbrt_pkg, bbrt_in_if, bbrt_out_if and bbrt_ram.
// Every action but an in-range add_bad goes from idle straight to the execute state, where
// the result goes into the output register once that is free. An in-range add_bad first
// scans the bad list, reading one entry per cycle through the single read port of the
// bad-list memory, and stops on a hit or after the last entry. Ready stays low until the
// result is loaded, so no new item is taken before then. A waiting result does not block
// the next accept; that item then waits after its accept. Reset (rst_ni low, asynchronous)
// restores register defaults, spare pointer and a zero count.
`timescale 1ns / 1ps

module bad_block_remap_table_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bbrt_in_if.sink                       in_if,
  bbrt_out_if.source                    out_if,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [bbrt_pkg::PADDR_W-1:0]  paddr_i,
  input  logic [bbrt_pkg::PDATA_W-1:0]  pwdata_i,
  output logic [bbrt_pkg::PDATA_W-1:0]  prdata_o,
  output logic                          pready_o
);

  localparam int BW = bbrt_pkg::BLK_W;
  localparam int CW = bbrt_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [BW-1:0] user_last_q, spare_first_q, spare_last_q;
  logic [1:0]    reg_idx;
  logic          cfg_we;

  // Item and table state
  logic [2:0]    action_q;
  logic [BW-1:0] blk_q, old_q;
  logic [BW-1:0] spare_ptr_q, spare_ptr_d;
  logic [CW-1:0] bad_total_q, bad_total_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic          found_q, found_d;

  // Output register
  logic                       out_valid_q;
  logic [BW-1:0]              out_mapped_q, out_mapped_d;
  logic [bbrt_pkg::STAT_W-1:0] out_status_q;
  bbrt_pkg::status_e          status_d;

  // Memory ports
  logic                         remap_we;
  logic [BW-1:0]                remap_wdata, remap_rdata;
  logic [bbrt_pkg::REMAP_AW-1:0] remap_raddr;
  logic                         list_we;
  logic [BW-1:0]                list_wdata, list_rdata;

  logic accept, exec_go, scan_issue, scan_hit;
  logic blk_in_range, blk_in_user, old_in_spare, spare_avail, list_full;

  // APB register file
  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[3:2];
  assign cfg_we   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      user_last_q   <= bbrt_pkg::USER_LAST_RST;
      spare_first_q <= bbrt_pkg::SPARE_FIRST_RST;
      spare_last_q  <= bbrt_pkg::SPARE_LAST_RST;
    end else if (cfg_we) begin
      unique case (reg_idx)
        bbrt_pkg::REG_USER_LAST:   user_last_q   <= pwdata_i[BW-1:0];
        bbrt_pkg::REG_SPARE_FIRST: spare_first_q <= pwdata_i[BW-1:0];
        bbrt_pkg::REG_SPARE_LAST:  spare_last_q  <= pwdata_i[BW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bbrt_pkg::REG_USER_LAST:   prdata_o = {{(bbrt_pkg::PDATA_W-BW){1'b0}}, user_last_q};
      bbrt_pkg::REG_SPARE_FIRST: prdata_o = {{(bbrt_pkg::PDATA_W-BW){1'b0}}, spare_first_q};
      bbrt_pkg::REG_SPARE_LAST:  prdata_o = {{(bbrt_pkg::PDATA_W-BW){1'b0}}, spare_last_q};
      default:                   prdata_o = '0;
    endcase
  end

  // Handshakes
  assign in_if.ready = (state_q == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign exec_go     = (state_q == S_EXEC) && (!out_valid_q || out_if.ready);

  // Memories: remap address follows the incoming block, then holds on the item
  assign remap_raddr = (state_q == S_IDLE) ? in_if.block[bbrt_pkg::REMAP_AW-1:0]
                                           : blk_q[bbrt_pkg::REMAP_AW-1:0];

  bbrt_ram #(.WIDTH(BW), .DEPTH(bbrt_pkg::BLOCK_COUNT)) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (remap_we),
    .waddr_i (blk_q[bbrt_pkg::REMAP_AW-1:0]),
    .wdata_i (remap_wdata),
    .raddr_i (remap_raddr),
    .rdata_o (remap_rdata)
  );

  bbrt_ram #(.WIDTH(BW), .DEPTH(bbrt_pkg::BAD_LIST_DEPTH)) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (bad_total_q[bbrt_pkg::LIST_AW-1:0]),
    .wdata_i (list_wdata),
    .raddr_i (idx_q[bbrt_pkg::LIST_AW-1:0]),
    .rdata_o (list_rdata)
  );

  // Range and availability checks
  assign blk_in_range = ({1'b0, blk_q} < bbrt_pkg::BLOCK_LIMIT);
  assign blk_in_user  = blk_in_range && (blk_q <= user_last_q);
  assign old_in_spare = (old_q >= spare_first_q) && (old_q <= spare_last_q);
  assign spare_avail  = (spare_ptr_q > spare_first_q);
  assign list_full    = (bad_total_q == bbrt_pkg::LIST_FULL);

  // Pipelined search: issue one read per cycle, compare the one returned
  assign scan_issue = (idx_q != bad_total_q);
  assign scan_hit   = pend_q && (list_rdata == blk_q);

  // Sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pend_d  = pend_q;
    found_d = found_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          idx_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          if (in_if.action == bbrt_pkg::ACT_ADD_BAD &&
              ({1'b0, in_if.block} < bbrt_pkg::BLOCK_LIMIT)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          found_d = 1'b1;
          state_d = S_EXEC;
        end else if (!scan_issue && !pend_q) begin
          state_d = S_EXEC;
        end else begin
          pend_d = scan_issue;
          if (scan_issue) begin
            idx_d = idx_q + CW'(1);
          end
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Action decode and table updates
  always_comb begin
    status_d    = bbrt_pkg::ST_OK;
    remap_we    = 1'b0;
    remap_wdata = blk_q;
    list_we     = 1'b0;
    list_wdata  = blk_q;
    spare_ptr_d = spare_ptr_q;
    bad_total_d = bad_total_q;
    unique case (action_q)
      bbrt_pkg::ACT_LOOKUP: begin
        if (!blk_in_range) status_d = bbrt_pkg::ST_RANGE;
      end
      bbrt_pkg::ACT_MAP_SELF: begin
        if (blk_in_user) begin
          remap_we = 1'b1;
        end else begin
          status_d = bbrt_pkg::ST_RANGE;
        end
      end
      bbrt_pkg::ACT_ADD_BAD: begin
        if (!blk_in_range) begin
          status_d = bbrt_pkg::ST_RANGE;
        end else if (found_q) begin
          status_d = bbrt_pkg::ST_LISTED;
        end else if (list_full) begin
          status_d = bbrt_pkg::ST_FULL;
        end else if (blk_in_user) begin
          if (!spare_avail) begin
            status_d = bbrt_pkg::ST_EXHAUSTED;
          end else begin
            remap_we    = 1'b1;
            remap_wdata = spare_ptr_q;
            spare_ptr_d = spare_ptr_q - BW'(1);
            list_we     = 1'b1;
            bad_total_d = bad_total_q + CW'(1);
          end
        end else begin
          list_we     = 1'b1;
          bad_total_d = bad_total_q + CW'(1);
        end
      end
      bbrt_pkg::ACT_REMAP: begin
        if (!blk_in_user || !old_in_spare) begin
          status_d = bbrt_pkg::ST_RANGE;
        end else if (remap_rdata != old_q) begin
          status_d = bbrt_pkg::ST_MISMATCH;
        end else if (blk_q == old_q) begin
          status_d = bbrt_pkg::ST_OK;
        end else if (!spare_avail) begin
          status_d = bbrt_pkg::ST_EXHAUSTED;
        end else begin
          remap_we    = 1'b1;
          remap_wdata = spare_ptr_q;
          spare_ptr_d = spare_ptr_q - BW'(1);
        end
      end
      bbrt_pkg::ACT_BAD_SPARE: begin
        if (list_full) begin
          status_d = bbrt_pkg::ST_FULL;
        end else if (!spare_avail) begin
          status_d = bbrt_pkg::ST_EXHAUSTED;
        end else begin
          list_we     = 1'b1;
          list_wdata  = spare_ptr_q;
          spare_ptr_d = spare_ptr_q - BW'(1);
          bad_total_d = bad_total_q + CW'(1);
        end
      end
      bbrt_pkg::ACT_RESTART: begin
        spare_ptr_d = spare_last_q;
        bad_total_d = '0;
      end
      default: status_d = bbrt_pkg::ST_RANGE;
    endcase

    // Only commit in the cycle the result is loaded
    remap_we = remap_we && exec_go;
    list_we  = list_we && exec_go;

    // Mapping as seen after the action
    if (!blk_in_range) begin
      out_mapped_d = '0;
    end else if (blk_in_user) begin
      out_mapped_d = remap_we ? remap_wdata : remap_rdata;
    end else begin
      out_mapped_d = blk_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      spare_ptr_q <= bbrt_pkg::SPARE_LAST_RST;
      bad_total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      found_q <= found_d;
      if (exec_go) begin
        spare_ptr_q <= spare_ptr_d;
        bad_total_q <= bad_total_d;
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= in_if.action;
      blk_q    <= in_if.block;
      old_q    <= in_if.old_replacement;
    end
    if (exec_go) begin
      out_mapped_q <= out_mapped_d;
      out_status_q <= status_d;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.mapped_block = out_mapped_q;
  assign out_if.status       = out_status_q;
  assign out_if.next_spare   = spare_ptr_q;
  assign out_if.bad_count    = bad_total_q;

endmodule

### hdl/bbrt_checker.sv
// Port-level checker for the bad block remap table core, with its bind.
// Depends on bbrt_pkg and on bad_block_remap_table_core's ports.
`timescale 1ns / 1ps

module bbrt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [bbrt_pkg::STAT_W-1:0] status_i,
  input logic [bbrt_pkg::CNT_W-1:0]  bad_count_i
);

  // A result stays offered until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before it was taken");

  // One item at a time: no accept in the cycle right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second item accepted while one is in work");

  // The list count saturates at the list depth
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> bad_count_i <= bbrt_pkg::LIST_FULL)
    else $error("bad count beyond list depth");

  // A full status reports a full list
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == bbrt_pkg::ST_FULL |-> bad_count_i == bbrt_pkg::LIST_FULL)
    else $error("list full reported with room left");

endmodule

bind bad_block_remap_table_core bbrt_checker u_bbrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .status_i    (out_if.status),
  .bad_count_i (out_if.bad_count)
);
